// ===== rtl/core/spjl_pkg.sv =====
`default_nettype none

package spjl_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_FORWARD_GAINS       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REVERSE_GAINS       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTEGRAL_LIMIT      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_ACCEL           = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_DECEL           = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_JERK_RATE           = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_FORWARD_STOP_DECEL  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_REVERSE_COAST_DECEL = 3'd7;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INC,
      ST_KP,
      ST_KI_NEW,
      ST_KI_OLD,
      ST_SQUARE,
      ST_STOP,
      ST_JERK,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      MUL_ERR_PERIOD,
      MUL_KP_ERR,
      MUL_KI_CAND,
      MUL_KI_INTEG,
      MUL_SQUARE,
      MUL_DECEL_DIST,
      MUL_JERK_PERIOD
   } mul_sel_type;

   typedef struct packed {
      logic        load;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        cand_en;
      logic        kperr_en;
      logic        sum_en;
      logic        cmd_en;
      logic        square_en;
      logic        stop_en;
      logic        finish_en;
   } ctrl_cmd_type;

   typedef struct packed {
      logic restart;
      logic out_free;
   } ctrl_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/spjl_ifs.sv =====
`default_nettype none

interface spjl_req_if;
   logic                valid;
   logic                ready;
   logic                op;
   logic signed [15:0]  target_speed;
   logic signed [15:0]  measured_speed;
   logic        [19:0]  distance_left;
   logic                stop_request;
   logic        [13:0]  period;

   modport source (
      output valid, op, target_speed, measured_speed, distance_left, stop_request, period,
      input  ready
   );
   modport sink (
      input  valid, op, target_speed, measured_speed, distance_left, stop_request, period,
      output ready
   );
endinterface

interface spjl_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [14:0] accel_command;

   modport source (output valid, accel_command, input ready);
   modport sink (input valid, accel_command, output ready);
endinterface

interface spjl_csr_if;
   logic                                valid;
   logic                                ready;
   logic [spjl_pkg::CSR_INDEX_W-1:0]    index;
   logic [spjl_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/speed_pi_jerk_limited.sv =====
// Velocity PI controller with jerk limit. One request word per control tick
// gives one acceleration command word. A control step runs seven products
// one after another through a single shared 18x21 multiplier: integral
// increment, kp*err, ki*integral twice, v^2, the stopping distance and the
// jerk step; a restart word skips them. The next request is accepted the
// cycle after a result is registered. One word is in work at a time; a new
// request is taken while the previous result still waits on the response
// channel, and its own result then holds until that one is taken. Settings
// are written on the csr channel, always ready; the user must write them
// only while the block is idle, which the block itself does not enforce.
`default_nettype none

module speed_pi_jerk_limited (
   input wire logic    clock,
   input wire logic    reset,
   spjl_req_if.sink    req_chan,
   spjl_rsp_if.source  rsp_chan,
   spjl_csr_if.sink    csr_chan
);

   spjl_pkg::ctrl_cmd_type    cmd;
   spjl_pkg::ctrl_status_type status;

   assign csr_chan.ready = 1'b1;

   spjl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   spjl_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_op             (req_chan.op),
      .req_target_speed   (req_chan.target_speed),
      .req_measured_speed (req_chan.measured_speed),
      .req_distance_left  (req_chan.distance_left),
      .req_stop_request   (req_chan.stop_request),
      .req_period         (req_chan.period),
      .csr_valid          (csr_chan.valid),
      .csr_index          (csr_chan.index),
      .csr_data           (csr_chan.data),
      .rsp_valid          (rsp_chan.valid),
      .rsp_ready          (rsp_chan.ready),
      .rsp_accel_command  (rsp_chan.accel_command)
   );

endmodule

`default_nettype wire

// ===== rtl/core/spjl_ctrl.sv =====
`default_nettype none

module spjl_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   output spjl_pkg::ctrl_cmd_type        cmd,
   input  wire spjl_pkg::ctrl_status_type status
);

   spjl_pkg::state_type state_ff;
   spjl_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spjl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd         = '0;
      cmd.mul_sel = spjl_pkg::MUL_ERR_PERIOD;
      unique case (state_ff)
         spjl_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = spjl_pkg::ST_INC;
            end
         end
         spjl_pkg::ST_INC: begin
            if (status.restart) begin
               state_in = spjl_pkg::ST_DONE;
            end else begin
               cmd.mul_en  = 1'b1;
               cmd.mul_sel = spjl_pkg::MUL_ERR_PERIOD;
               state_in    = spjl_pkg::ST_KP;
            end
         end
         spjl_pkg::ST_KP: begin
            cmd.cand_en = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = spjl_pkg::MUL_KP_ERR;
            state_in    = spjl_pkg::ST_KI_NEW;
         end
         spjl_pkg::ST_KI_NEW: begin
            cmd.kperr_en = 1'b1;
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = spjl_pkg::MUL_KI_CAND;
            state_in     = spjl_pkg::ST_KI_OLD;
         end
         spjl_pkg::ST_KI_OLD: begin
            cmd.sum_en  = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = spjl_pkg::MUL_KI_INTEG;
            state_in    = spjl_pkg::ST_SQUARE;
         end
         spjl_pkg::ST_SQUARE: begin
            cmd.cmd_en  = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = spjl_pkg::MUL_SQUARE;
            state_in    = spjl_pkg::ST_STOP;
         end
         spjl_pkg::ST_STOP: begin
            cmd.square_en = 1'b1;
            cmd.mul_en    = 1'b1;
            cmd.mul_sel   = spjl_pkg::MUL_DECEL_DIST;
            state_in      = spjl_pkg::ST_JERK;
         end
         spjl_pkg::ST_JERK: begin
            cmd.stop_en = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = spjl_pkg::MUL_JERK_PERIOD;
            state_in    = spjl_pkg::ST_DONE;
         end
         spjl_pkg::ST_DONE: begin
            if (status.out_free) begin
               cmd.finish_en = 1'b1;
               state_in      = spjl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = spjl_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/spjl_dp.sv =====
`default_nettype none

module spjl_dp (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire spjl_pkg::ctrl_cmd_type           cmd,
   output spjl_pkg::ctrl_status_type             status,
   input  wire logic                             req_op,
   input  wire logic signed [15:0]               req_target_speed,
   input  wire logic signed [15:0]               req_measured_speed,
   input  wire logic        [19:0]               req_distance_left,
   input  wire logic                             req_stop_request,
   input  wire logic        [13:0]               req_period,
   input  wire logic                             csr_valid,
   input  wire logic [spjl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [spjl_pkg::CSR_DATA_W-1:0]  csr_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic signed [14:0]                    rsp_accel_command
);

   // settings
   logic [23:0] fwd_gains_ff;
   logic [23:0] rev_gains_ff;
   logic [15:0] ilim_ff;
   logic [13:0] max_accel_ff;
   logic [13:0] max_decel_ff;
   logic [15:0] jerk_rate_ff;
   logic [13:0] fwd_stop_ff;
   logic [13:0] rev_coast_ff;

   // captured word
   logic               op_ff;
   logic signed [15:0] tgt_ff;
   logic signed [15:0] meas_ff;
   logic        [19:0] dist_ff;
   logic               stop_ff;
   logic        [13:0] period_ff;

   // state
   logic signed [16:0] integ_ff;
   logic signed [15:0] last_ff;

   // working registers
   logic signed [38:0] prod_ff;
   logic signed [16:0] cand_ff;
   logic signed [29:0] kperr_ff;
   logic signed [30:0] sum1_ff;
   logic               upd_ff;
   logic signed [15:0] cmd_ff;
   logic        [30:0] sq_ff;
   logic               rsp_valid_ff;
   logic signed [14:0] rsp_data_ff;

   // decode
   logic signed [16:0] err;
   logic        [15:0] atgt;
   logic        [15:0] ameas;
   logic               tgt_zero;
   logic               rev;
   logic               braking;
   logic        [23:0] gains;
   logic        [11:0] kp;
   logic        [11:0] ki;
   logic        [13:0] lim;
   logic        [13:0] stop_decel;
   logic               err_neg;
   logic               err_pos;

   // multiplier
   logic signed [17:0] mul_a;
   logic signed [20:0] mul_b;

   // integral candidate
   logic signed [30:0] inc_v;
   logic        [30:0] inc_mag;
   logic        [31:0] inc_round;
   logic signed [15:0] inc_p;
   logic signed [15:0] inc;
   logic signed [17:0] csum;
   logic signed [17:0] ilim18;
   logic signed [17:0] cand_w;
   logic signed [16:0] cand_in;

   // saturation test
   logic signed [30:0] sum1_in;
   logic signed [30:0] lim256;
   logic               sat_hi;
   logic               sat_lo;
   logic               upd_in;

   // command
   logic signed [30:0] sum2;
   logic        [30:0] sum2_mag;
   logic        [31:0] sum2_round;
   logic signed [23:0] rnd_p;
   logic signed [23:0] rnd;
   logic signed [23:0] lim24;
   logic signed [23:0] clamp24;
   logic signed [15:0] cmd_in;

   // stop override
   logic        [34:0] need_ext;
   logic        [34:0] stop_dist;
   logic               stop_hit;
   logic signed [15:0] decel16;
   logic signed [15:0] stop_cmd;

   // jerk limit
   logic        [30:0] jerk_round;
   logic        [14:0] step;
   logic signed [16:0] last17;
   logic signed [16:0] step17;
   logic signed [16:0] jlo;
   logic signed [16:0] jhi;
   logic signed [16:0] c17;
   logic signed [16:0] final_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_gains_ff <= 24'd384;
         rev_gains_ff <= 24'd384;
         ilim_ff      <= 16'd512;
         max_accel_ff <= 14'd512;
         max_decel_ff <= 14'd1024;
         jerk_rate_ff <= 16'd2048;
         fwd_stop_ff  <= 14'd1126;
         rev_coast_ff <= 14'd1843;
      end else if (csr_valid) begin
         unique case (csr_index)
            spjl_pkg::CSR_FORWARD_GAINS:       fwd_gains_ff <= csr_data[23:0];
            spjl_pkg::CSR_REVERSE_GAINS:       rev_gains_ff <= csr_data[23:0];
            spjl_pkg::CSR_INTEGRAL_LIMIT:      ilim_ff      <= csr_data[15:0];
            spjl_pkg::CSR_MAX_ACCEL:           max_accel_ff <= csr_data[13:0];
            spjl_pkg::CSR_MAX_DECEL:           max_decel_ff <= csr_data[13:0];
            spjl_pkg::CSR_JERK_RATE:           jerk_rate_ff <= csr_data[15:0];
            spjl_pkg::CSR_FORWARD_STOP_DECEL:  fwd_stop_ff  <= csr_data[13:0];
            spjl_pkg::CSR_REVERSE_COAST_DECEL: rev_coast_ff <= csr_data[13:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_op;
         tgt_ff    <= req_target_speed;
         meas_ff   <= req_measured_speed;
         dist_ff   <= req_distance_left;
         stop_ff   <= req_stop_request;
         period_ff <= req_period;
      end
   end

   always_comb begin
      err      = 17'(tgt_ff) - 17'(meas_ff);
      err_neg  = err[16];
      err_pos  = !err[16] && (err != 17'sd0);
      atgt     = tgt_ff[15] ? 16'(-tgt_ff) : 16'(tgt_ff);
      ameas    = meas_ff[15] ? 16'(-meas_ff) : 16'(meas_ff);
      tgt_zero = atgt <= 16'd1;
      rev      = (tgt_ff < -16'sd1) || (tgt_zero && meas_ff[15]);
      braking  = (atgt < ameas) || (tgt_ff[15] && meas_ff > 16'sd0)
               || (tgt_ff > 16'sd0 && meas_ff[15]);
      gains      = rev ? rev_gains_ff : fwd_gains_ff;
      kp         = gains[11:0];
      ki         = gains[23:12];
      lim        = braking ? max_decel_ff : max_accel_ff;
      stop_decel = rev ? rev_coast_ff : fwd_stop_ff;
   end

   // shared multiplier, one product per cycle
   always_comb begin
      unique case (cmd.mul_sel)
         spjl_pkg::MUL_ERR_PERIOD: begin
            mul_a = {err[16], err};
            mul_b = {7'd0, period_ff};
         end
         spjl_pkg::MUL_KP_ERR: begin
            mul_a = {err[16], err};
            mul_b = {9'd0, kp};
         end
         spjl_pkg::MUL_KI_CAND: begin
            mul_a = {cand_ff[16], cand_ff};
            mul_b = {9'd0, ki};
         end
         spjl_pkg::MUL_KI_INTEG: begin
            mul_a = {integ_ff[16], integ_ff};
            mul_b = {9'd0, ki};
         end
         spjl_pkg::MUL_SQUARE: begin
            mul_a = {2'd0, ameas};
            mul_b = {5'd0, ameas};
         end
         spjl_pkg::MUL_DECEL_DIST: begin
            mul_a = {4'd0, stop_decel};
            mul_b = {1'b0, dist_ff};
         end
         spjl_pkg::MUL_JERK_PERIOD: begin
            mul_a = {2'd0, jerk_rate_ff};
            mul_b = {7'd0, period_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
   end

   // integral candidate: integral plus err*period >> 16, rounded away from zero, clamped
   always_comb begin
      inc_v     = prod_ff[30:0];
      inc_mag   = inc_v[30] ? 31'(-inc_v) : 31'(inc_v);
      inc_round = {1'b0, inc_mag} + 32'h0000_8000;
      inc_p     = {1'b0, inc_round[30:16]};
      inc       = inc_v[30] ? -inc_p : inc_p;
      csum      = {integ_ff[16], integ_ff} + {{2{inc[15]}}, inc};
      ilim18    = {2'd0, ilim_ff};
      if (csum > ilim18) begin
         cand_w = ilim18;
      end else if (csum < -ilim18) begin
         cand_w = -ilim18;
      end else begin
         cand_w = csum;
      end
      cand_in = cand_w[16:0];
   end

   // PI sum with candidate, saturation check
   always_comb begin
      sum1_in = {kperr_ff[29], kperr_ff} + {prod_ff[29], prod_ff[29:0]};
      lim256  = {9'd0, lim, 8'd0};
      sat_hi  = sum1_in > lim256;
      sat_lo  = sum1_in < -lim256;
      upd_in  = (!sat_hi && !sat_lo) || (sat_hi && err_neg) || (sat_lo && err_pos);
   end

   // PI sum with committed integral, >> 8 rounded, clamped to limit
   always_comb begin
      sum2       = upd_ff ? sum1_ff
                 : ({kperr_ff[29], kperr_ff} + {prod_ff[29], prod_ff[29:0]});
      sum2_mag   = sum2[30] ? 31'(-sum2) : 31'(sum2);
      sum2_round = {1'b0, sum2_mag} + 32'd128;
      rnd_p      = {1'b0, sum2_round[30:8]};
      rnd        = sum2[30] ? -rnd_p : rnd_p;
      lim24      = {10'd0, lim};
      if (rnd < -lim24) begin
         clamp24 = -lim24;
      end else if (rnd > lim24) begin
         clamp24 = lim24;
      end else begin
         clamp24 = rnd;
      end
      cmd_in = clamp24[15:0];
   end

   // stop override: v^2 >= 2*decel*distance
   always_comb begin
      need_ext  = {4'd0, sq_ff};
      stop_dist = {prod_ff[33:0], 1'b0};
      stop_hit  = stop_ff && (ameas > 16'd1) && (need_ext >= stop_dist);
      decel16   = {2'd0, max_decel_ff};
      stop_cmd  = (meas_ff > 16'sd0) ? -decel16 : decel16;
   end

   // jerk limit around last command
   always_comb begin
      jerk_round = prod_ff[30:0] + 31'h0000_8000;
      step       = jerk_round[30:16];
      last17     = {last_ff[15], last_ff};
      step17     = {2'd0, step};
      jlo        = last17 - step17;
      jhi        = last17 + step17;
      c17        = {cmd_ff[15], cmd_ff};
      if (op_ff) begin
         final_in = '0;
      end else if (jerk_rate_ff == 16'd0) begin
         final_in = c17;
      end else if (c17 < jlo) begin
         final_in = jlo;
      end else if (c17 > jhi) begin
         final_in = jhi;
      end else begin
         final_in = c17;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cand_en) begin
         cand_ff <= cand_in;
      end
      if (cmd.kperr_en) begin
         kperr_ff <= prod_ff[29:0];
      end
      if (cmd.sum_en) begin
         sum1_ff <= sum1_in;
         upd_ff  <= upd_in;
      end
      if (cmd.square_en) begin
         sq_ff <= prod_ff[30:0];
      end
      if (cmd.cmd_en) begin
         cmd_ff <= cmd_in;
      end else if (cmd.stop_en && stop_hit) begin
         cmd_ff <= stop_cmd;
      end
      if (cmd.finish_en) begin
         rsp_data_ff <= final_in[14:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff     <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.cmd_en && upd_ff) begin
            integ_ff <= cand_ff;
         end else if (cmd.stop_en && stop_hit) begin
            integ_ff <= '0;
         end else if (cmd.finish_en && op_ff) begin
            integ_ff <= '0;
         end
         if (cmd.finish_en) begin
            last_ff <= final_in[15:0];
         end
         if (cmd.finish_en) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.restart    = op_ff;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accel_command = rsp_data_ff;

endmodule

`default_nettype wire
